// ===== sv/projection_profile_run_segmenter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the projection profile run segmenter
// Shorthands for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef PROJECTION_PROFILE_RUN_SEGMENTER_ASSERT_SVH
`define PROJECTION_PROFILE_RUN_SEGMENTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segmenter assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segmenter assertion failed");

`endif

// ===== sv/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared widths, register codes and types of the run segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 4096;

  localparam int PIX_W    = 64;
  localparam int GROUP_W  = 8;
  localparam int GROUPS   = (MAX_ROWS + GROUP_W - 1) / GROUP_W;
  localparam int PART_W   = $clog2(GROUP_W + 1);
  localparam int BLACK_W  = $clog2(MAX_ROWS + 1);

  localparam int THR_W    = 7;
  localparam int SPAN_W   = 13;
  localparam int ROWS_W   = 7;

  localparam int START_W  = 12;
  localparam int COL_W    = 13;
  localparam int SEGCNT_W = 13;
  localparam logic [SEGCNT_W-1:0] COUNT_CEIL = {SEGCNT_W{1'b1}};
  localparam logic [COL_W-1:0]    COL_LIMIT  = COL_W'(MAX_COLUMNS);

  localparam int MID_DEPTH = 4;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_NOISE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_SPAN        = 2'd1;
  localparam logic [1:0] REG_ROWS_IN_USE     = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]  noise_threshold;
    logic [SPAN_W-1:0] min_span;
    logic [ROWS_W-1:0] rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic ink;
    logic last;
  } class_t;

  typedef struct packed {
    logic                found;
    logic [START_W-1:0]  start;
    logic [COL_W-1:0]    seg_end;
    logic [SEGCNT_W-1:0] count;
    logic                done;
    logic                ovf;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/projection_profile_run_segmenter.sv =====
// ----------------------------------------------------------------------------
// projection_profile_run_segmenter
// Projection profile segmentation of a binary image, one column per item.
//
//   channel   direction  handshake            payload
//   columns   in         push / full          column_pixels, frame_last
//   results   out        pop / empty          segment_found .. column_overflow
//   config    in         psel penable pwrite  paddr, pwdata, prdata
//
// One column per cycle sustained while the result side keeps up. A column
// is registered in the popcount front end and written into the column queue,
// then the run tracker handles it and writes its result into the result
// queue; the result ports show the head of that queue.
// Reset is synchronous and empties all queues; no clearing pass is needed.
// A stalled result side fills the two-entry result queue, then the
// four-entry column queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module projection_profile_run_segmenter import prs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [PIX_W-1:0]    column_pixels,
  input  wire logic                frame_last,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     segment_found,
  output logic [START_W-1:0]       segment_start,
  output logic [COL_W-1:0]         segment_end,
  output logic [SEGCNT_W-1:0]      segment_count,
  output logic                     frame_done,
  output logic                     column_overflow,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t    cfg;
  logic    cfg_wr;
  logic    mid_full;
  logic    mid_push;
  class_t  mid_data;
  class_t  mid_head;
  logic    mid_empty;
  logic    mid_pop;
  result_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_threshold <= THR_W'(1);
      cfg.min_span        <= SPAN_W'(3);
      cfg.rows_in_use     <= ROWS_W'(MAX_ROWS);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NOISE_THRESHOLD: cfg.noise_threshold <= pwdata[THR_W-1:0];
        REG_MIN_SPAN:        cfg.min_span        <= pwdata[SPAN_W-1:0];
        REG_ROWS_IN_USE:     cfg.rows_in_use     <= pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NOISE_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, cfg.noise_threshold};
      REG_MIN_SPAN:        prdata = {{(32-SPAN_W){1'b0}}, cfg.min_span};
      REG_ROWS_IN_USE:     prdata = {{(32-ROWS_W){1'b0}}, cfg.rows_in_use};
      default:             prdata = '0;
    endcase
  end

  prs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .column_pixels (column_pixels),
    .frame_last    (frame_last),
    .cfg           (cfg),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_data      (mid_data)
  );

  prs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_data),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_head),
    .empty   (mid_empty)
  );

  prs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (mid_head),
    .head_valid (!mid_empty),
    .head_pop   (mid_pop),
    .min_span   (cfg.min_span),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  assign segment_found   = result.found;
  assign segment_start   = result.start;
  assign segment_end     = result.seg_end;
  assign segment_count   = result.count;
  assign frame_done      = result.done;
  assign column_overflow = result.ovf;

endmodule

`default_nettype wire

// ===== sv/prs_front.sv =====
// ----------------------------------------------------------------------------
// prs_front
// Counts black pixels of a column in two steps and classifies it as ink.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_front import prs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [PIX_W-1:0] column_pixels,
  input  wire logic             frame_last,
  input  wire cfg_t             cfg,
  input  wire logic             mid_full,
  output logic                  mid_push,
  output class_t                mid_data
);

  logic                  s1_valid;
  logic                  s1_last;
  logic [PART_W-1:0]     s1_part [GROUPS];
  logic [PART_W-1:0]     part [GROUPS];
  logic [ROWS_W-1:0]     rows_eff;
  logic [BLACK_W-1:0]    black;
  logic                  accept;

  localparam logic [ROWS_W-1:0] ROWS_LIMIT = ROWS_W'(MAX_ROWS);

  assign rows_eff = (cfg.rows_in_use > ROWS_LIMIT) ? ROWS_LIMIT : cfg.rows_in_use;

  // per-group black counts over the rows in use
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part[g] = '0;
      for (int j = 0; j < GROUP_W; j++) begin
        if ((g * GROUP_W + j) < MAX_ROWS) begin
          if (ROWS_W'(g * GROUP_W + j) < rows_eff && !column_pixels[g * GROUP_W + j]) begin
            part[g] = part[g] + PART_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    black = '0;
    for (int g = 0; g < GROUPS; g++) begin
      black = black + BLACK_W'(s1_part[g]);
    end
  end

  assign mid_push      = s1_valid && !mid_full;
  assign full          = s1_valid && mid_full;
  assign accept        = push && !full;
  assign mid_data.ink  = ({1'b0, black} > {1'b0, cfg.noise_threshold});
  assign mid_data.last = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (mid_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_part <= part;
      s1_last <= frame_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/prs_queue.sv =====
// ----------------------------------------------------------------------------
// prs_queue
// Short queue of classified columns between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_queue import prs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire class_t wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output class_t      rd_data,
  output logic        empty
);

  localparam int PTR_W = $clog2(MID_DEPTH);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  class_t             mem [MID_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W'(MID_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/prs_back.sv =====
// ----------------------------------------------------------------------------
// prs_back
// Tracks ink runs across columns and queues the segment results.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_back import prs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire class_t              head,
  input  wire logic                head_valid,
  output logic                     head_pop,
  input  wire logic [SPAN_W-1:0]   min_span,
  output logic                     empty,
  input  wire logic                pop,
  output result_t                  result
);

  logic [COL_W-1:0]    column_index;
  logic                in_run;
  logic [START_W-1:0]  run_start;
  logic [SEGCNT_W-1:0] found_count;
  logic                overflowed;

  logic                over;
  logic                ink;
  logic                closed;
  logic [START_W-1:0]  seg_start;
  logic [COL_W-1:0]    seg_end;
  logic [COL_W-1:0]    seg_len;
  logic                found;
  logic [SEGCNT_W-1:0] found_count_next;
  logic                overflowed_next;
  logic                emit;
  result_t             res;

  result_t             oq [2];
  logic                oq_wr;
  logic                oq_rd;
  logic [1:0]          oq_count;
  logic                oq_full;
  logic                oq_push;
  logic                oq_pop;

  assign oq_full  = (oq_count == 2'd2);
  assign head_pop = head_valid && !oq_full;

  // columns past the limit count as white at the limit index
  assign over      = (column_index >= COL_LIMIT);
  assign ink       = head.ink && !over;
  assign seg_start = (ink && !in_run) ? column_index[START_W-1:0] : run_start;
  assign seg_end   = ink ? column_index + COL_W'(1) : column_index;
  assign closed    = (ink && head.last) || (!ink && in_run);
  assign seg_len   = seg_end - {{(COL_W-START_W){1'b0}}, seg_start};
  assign found     = closed && (seg_len > min_span);
  assign found_count_next = (found && found_count < COUNT_CEIL) ?
                            found_count + SEGCNT_W'(1) : found_count;
  assign overflowed_next  = overflowed || over;
  assign emit = found || head.last;

  always_comb begin
    res.found   = found;
    res.start   = found ? seg_start : '0;
    res.seg_end = found ? seg_end : '0;
    res.count   = found_count_next;
    res.done    = head.last;
    res.ovf     = overflowed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      in_run       <= 1'b0;
      run_start    <= '0;
      found_count  <= '0;
      overflowed   <= 1'b0;
    end else if (head_pop) begin
      if (head.last) begin
        column_index <= '0;
        in_run       <= 1'b0;
        run_start    <= '0;
        found_count  <= '0;
        overflowed   <= 1'b0;
      end else begin
        if (!over) begin
          column_index <= column_index + COL_W'(1);
        end
        in_run      <= closed ? 1'b0 : (ink || in_run);
        run_start   <= seg_start;
        found_count <= found_count_next;
        overflowed  <= overflowed_next;
      end
    end
  end

  // two-entry result queue
  assign oq_push = head_pop && emit;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_count == 2'd0);
  assign result  = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wr <= !oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= !oq_rd;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 2'd1;
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/prs_checker.sv =====
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks on the results of the run segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "projection_profile_run_segmenter_assert.svh"

module prs_checker import prs_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                empty,
  input wire logic                pop,
  input wire logic                segment_found,
  input wire logic [START_W-1:0]  segment_start,
  input wire logic [COL_W-1:0]    segment_end,
  input wire logic [SEGCNT_W-1:0] segment_count,
  input wire logic                frame_done
);

  // an empty result carries no span
  `PRS_ASSERT_NOW(a_no_seg_zero, !empty && !segment_found,
                  segment_start == '0 && segment_end == '0)
  // only the frame's last column may give a result without a segment
  `PRS_ASSERT_NOW(a_result_reason, !empty && !frame_done, segment_found)
  `PRS_ASSERT_NOW(a_span_order, !empty && segment_found,
                  segment_end > {1'b0, segment_start})
  `PRS_ASSERT_NOW(a_count_nonzero, !empty && segment_found, segment_count != '0)
  // a waiting result is not dropped without a pop
  `PRS_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty)

endmodule

bind projection_profile_run_segmenter prs_checker u_checker (.*);

`default_nettype wire
